### design/oqa_pkg.sv
// Shared types and constants for the owned queue id allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package oqa_pkg;

   localparam int NUM_QUEUES_DEF = 16;
   localparam int OWNER_W        = 16;
   localparam int FIELD_W        = 4;

   localparam logic REQ_ALLOCATE = 1'b0;
   localparam logic REQ_RELEASE  = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture requester, rewind the scan
      logic alloc_step;  // test one queue for allocation
      logic rel_issue;   // read one owner entry for release
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic free_hit;    // queue under the scan pointer is free
      logic idx_last;    // scan pointer is at the last queue
   } dp_status_type;

endpackage

### design/oqa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oqa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/oqa_datapath.sv
// Datapath: used map, owner RAM, scan pointer, release check stage and result registers.
// Depends on oqa_pkg and oqa_ram.
module oqa_datapath #(
   parameter int NUM_QUEUES = oqa_pkg::NUM_QUEUES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  oqa_pkg::ctl_cmd_type         cmd,
   output oqa_pkg::dp_status_type       status,
   input  logic [oqa_pkg::OWNER_W-1:0]  req_requester,
   output logic                         rsp_status,
   output logic [oqa_pkg::FIELD_W-1:0]  rsp_qnum,
   output logic [oqa_pkg::FIELD_W-1:0]  rsp_released_count
);

   localparam int IDX_W = $clog2(NUM_QUEUES);
   localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_QUEUES - 1);

   logic [oqa_pkg::OWNER_W-1:0] who_ff, who_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]            chk_idx_ff, chk_idx_in;
   logic [NUM_QUEUES-1:0]       used_ff, used_in;
   logic [IDX_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            qid_ff, qid_in;
   logic                        status_ff, status_in;

   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [oqa_pkg::OWNER_W-1:0] wr_data;
   logic [oqa_pkg::OWNER_W-1:0] rd_data;

   oqa_ram #(
      .WIDTH (oqa_pkg::OWNER_W),
      .DEPTH (NUM_QUEUES)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign status.free_hit = !used_ff[idx_ff];
   assign status.idx_last = (idx_ff == IDX_LAST);

   always_comb begin
      who_in       = who_ff;
      idx_in       = idx_ff;
      chk_valid_in = cmd.rel_issue;
      chk_idx_in   = idx_ff;
      used_in      = used_ff;
      count_in     = count_ff;
      qid_in       = qid_ff;
      status_in    = status_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = who_ff;

      if (cmd.load) begin
         who_in    = req_requester;
         idx_in    = IDX_FIRST;
         count_in  = '0;
         qid_in    = '0;
         status_in = oqa_pkg::STATUS_OK;
      end

      if (cmd.alloc_step) begin
         if (!used_ff[idx_ff]) begin
            used_in[idx_ff] = 1'b1;
            wr_en           = 1'b1;
            qid_in          = idx_ff;
         end else if (idx_ff != IDX_LAST) begin
            idx_in = idx_ff + IDX_W'(1);
         end else begin
            status_in = oqa_pkg::STATUS_FULL;
         end
      end

      // hold the pointer on the last queue so it never leaves the table
      if (cmd.rel_issue && (idx_ff != IDX_LAST)) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      // owner data for chk_idx arrives in the cycle after its read was issued
      if (chk_valid_ff && used_ff[chk_idx_ff] && (rd_data == who_ff)) begin
         used_in[chk_idx_ff] = 1'b0;
         wr_en               = 1'b1;
         wr_addr             = chk_idx_ff;
         wr_data             = '0;
         count_in            = count_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff <= 1'b0;
         used_ff      <= NUM_QUEUES'(1);
      end else begin
         chk_valid_ff <= chk_valid_in;
         used_ff      <= used_in;
      end
      who_ff     <= who_in;
      idx_ff     <= idx_in;
      chk_idx_ff <= chk_idx_in;
      count_ff   <= count_in;
      qid_ff     <= qid_in;
      status_ff  <= status_in;
   end

   assign rsp_status         = status_ff;
   assign rsp_qnum           = oqa_pkg::FIELD_W'(qid_ff);
   assign rsp_released_count = oqa_pkg::FIELD_W'(count_ff);

`ifndef ASSERT_OFF
   a_reserved_used: assert property (@(posedge clock) disable iff (reset)
      used_ff[0])
      else $error("reserved queue left the used map");

   a_no_check_in_alloc: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_step |-> !chk_valid_ff)
      else $error("release check active during allocation scan");

   a_alloc_sets_one: assert property (@(posedge clock) disable iff (reset)
      (cmd.alloc_step && status.free_hit) |=>
         ($countones(used_ff) == $countones($past(used_ff)) + 1))
      else $error("allocation did not mark exactly one queue");
`endif

endmodule

### design/oqa_ctrl.sv
// Controller state machine: sequences allocate and release scans over the datapath.
// Depends on oqa_pkg.
module oqa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_type,
   output logic                   busy,
   output logic                   rsp_valid,
   output oqa_pkg::ctl_cmd_type   cmd,
   input  oqa_pkg::dp_status_type status
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_ALLOC    = 5'b00010,
      S_REL      = 5'b00100,
      S_REL_LAST = 5'b01000,
      S_DONE     = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.load       = 1'b0;
      cmd.alloc_step = 1'b0;
      cmd.rel_issue  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_type == oqa_pkg::REQ_ALLOCATE) ? S_ALLOC : S_REL;
            end
         end
         S_ALLOC: begin
            cmd.alloc_step = 1'b1;
            if (status.free_hit || status.idx_last) begin
               state_in = S_DONE;
            end
         end
         S_REL: begin
            cmd.rel_issue = 1'b1;
            if (status.idx_last) begin
               state_in = S_REL_LAST;
            end
         end
         S_REL_LAST: begin
            // drain the check of the last owner entry
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
`endif

endmodule

### design/owned_queue_id_allocator.sv
// Owned queue id allocator: an allocate takes the lowest free queue, a release frees all
// queues of one requester. An allocate tests the used map one queue per step from queue 1
// until it finds a free one or reaches the last; a release reads the owner RAM one entry
// per cycle. One item at a time: busy stays high through the strobe cycle, so a new item
// is accepted only after the strobe has ended.
// Results cannot be stalled. Synchronous reset: queue 0 marked used, all others free.
module owned_queue_id_allocator #(
   parameter int NUM_QUEUES = oqa_pkg::NUM_QUEUES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_type,
   input  logic [oqa_pkg::OWNER_W-1:0] req_requester,
   output logic                        rsp_valid,
   output logic                        rsp_status,
   output logic [oqa_pkg::FIELD_W-1:0] rsp_qnum,
   output logic [oqa_pkg::FIELD_W-1:0] rsp_released_count
);

   oqa_pkg::ctl_cmd_type   cmd;
   oqa_pkg::dp_status_type dp_status;

   oqa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (dp_status)
   );

   oqa_datapath #(
      .NUM_QUEUES (NUM_QUEUES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (dp_status),
      .req_requester      (req_requester),
      .rsp_status         (rsp_status),
      .rsp_qnum           (rsp_qnum),
      .rsp_released_count (rsp_released_count)
   );

endmodule
